// File: design/bbcm_pkg.sv
package bbcm_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int COUNT_BITS  = 8;
  localparam int EW          = $clog2(NUM_ENTRIES);
  localparam int LW          = $clog2(NUM_ENTRIES + 1);
  localparam int QDEPTH      = 2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] OP_GET     = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_WB      = 3'd3;
  localparam logic [2:0] OP_SETD    = 3'd4;
  localparam logic [2:0] OP_SYNC    = 3'd5;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  device;
    logic [31:0] block;
    logic [4:0]  entry;
    logic        dirty_flag;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  entry_out;
    logic [7:0]  device_out;
    logic [34:0] sector;
    logic        hit;
    logic [1:0]  status;
    logic        wake_waiter;
    logic        last;
  } out_res_t;

endpackage

// File: design/bbcm_queue.sv
module bbcm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bbcm_pkg::in_req_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output bbcm_pkg::in_req_t rd_data,
  output logic              empty
);
  import bbcm_pkg::*;

  in_req_t mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0]   cnt_r;

  assign full    = (cnt_r == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QDEPTH){1'b0}}, wr_en} - {{$clog2(QDEPTH){1'b0}}, rd_en};
    end
  end
endmodule

// File: design/bbcm_engine.sv
module bbcm_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         spb,
  input  logic               q_empty,
  input  bbcm_pkg::in_req_t  q_data,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  output bbcm_pkg::out_res_t out_data,
  input  logic               out_stall
);
  import bbcm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_SYNC  = 6'b001000,
    S_MUL   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]            tdev_r [NUM_ENTRIES];
  logic [31:0]           tblk_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] use_r, fill_r, dirty_r;
  logic [COUNT_BITS-1:0] cnt_r [NUM_ENTRIES];
  logic [LW-1:0]         handed_r;
  logic [EW-1:0]         rel_r [NUM_ENTRIES];
  logic [LW-1:0]         rlen_r;
  logic [EW-1:0]         dord_r [NUM_ENTRIES];
  logic [LW-1:0]         dlen_r;

  in_req_t               req_r;
  logic                  found_r;
  logic [EW-1:0]         fidx_r;
  logic [LW-1:0]         nsync_r;

  // pending results: up to two per lookup
  out_res_t              res_r [2];
  logic [31:0]           mblk_r [2];
  logic [1:0]            rnum_r;
  logic                  ridx_r;

  out_res_t              obuf_r;
  logic                  ovld_r;

  // tag search
  logic                  hit_c;
  logic [EW-1:0]         hidx_c;
  always_comb begin
    hit_c  = 1'b0;
    hidx_c = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if ((LW'(i) < handed_r) && use_r[i] && tdev_r[i] == req_r.device &&
          tblk_r[i] == req_r.block) begin
        hit_c  = 1'b1;
        hidx_c = EW'(i);
      end
    end
  end

  logic ent_ok;
  assign ent_ok = ({1'b0, req_r.entry} < (EW+1)'(handed_r)) &&
                  (int'(req_r.entry) < NUM_ENTRIES);

  logic [EW-1:0] ee;
  assign ee = EW'(req_r.entry);

  function automatic out_res_t ack(logic [4:0] e, logic h, logic [1:0] st, logic w);
    out_res_t r;
    r = '0;
    r.kind = KIND_ACK; r.entry_out = e; r.hit = h; r.status = st;
    r.wake_waiter = w; r.last = 1'b1;
    return r;
  endfunction

  logic out_free;
  assign out_free  = !ovld_r || !out_stall;
  assign out_valid = ovld_r;
  assign out_data  = obuf_r;
  assign busy      = (state_r != S_IDLE);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  logic [EW-1:0] de;
  assign de = dord_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      use_r    <= '0;
      fill_r   <= '0;
      dirty_r  <= '0;
      handed_r <= '0;
      rlen_r   <= '0;
      dlen_r   <= '0;
      ovld_r   <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) cnt_r[i] <= '0;
    end else begin
      if (ovld_r && !out_stall && state_r != S_SYNC && state_r != S_EMIT)
        ovld_r <= 1'b0;
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) req_r <= q_data;
          rnum_r <= '0;
          ridx_r <= 1'b0;
          nsync_r <= '0;
        end
        S_SRCH: begin
          found_r <= hit_c;
          fidx_r  <= hidx_c;
        end
        S_EXEC: begin
          case (req_r.opcode)
            OP_GET, OP_READ: begin
              if (found_r) begin
                if (!fill_r[fidx_r] || cnt_r[fidx_r] == COUNT_MAX) begin
                  res_r[0] <= ack(5'(fidx_r), 1'b1, ST_BUSY, 1'b0);
                  rnum_r <= 2'd1;
                end else begin
                  cnt_r[fidx_r] <= cnt_r[fidx_r] + 1'b1;
                  if (cnt_r[fidx_r] == '0) begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                      if (LW'(i) < rlen_r && rel_r[i] == fidx_r) begin
                        for (int j = i; j < NUM_ENTRIES - 1; j++)
                          rel_r[j] <= rel_r[j+1];
                      end
                    end
                    rlen_r <= rlen_r - 1'b1;
                  end
                  res_r[0] <= ack(5'(fidx_r), 1'b1, ST_OK, 1'b0);
                  rnum_r <= 2'd1;
                end
              end else begin : miss
                logic [EW-1:0] v;
                logic ok, wr;
                out_res_t r1;
                v  = '0;
                ok = 1'b1;
                wr = 1'b0;
                if (handed_r < LW'(NUM_ENTRIES)) begin
                  v = EW'(handed_r);
                  handed_r <= handed_r + 1'b1;
                  dirty_r[v] <= 1'b0;
                end else if (rlen_r != '0) begin
                  v = rel_r[EW'(rlen_r - 1'b1)];
                  rlen_r <= rlen_r - 1'b1;
                  wr = dirty_r[v];
                end else begin
                  ok = 1'b0;
                end
                if (!ok) begin
                  res_r[0] <= ack(5'd0, 1'b0, ST_NOFREE, 1'b0);
                  rnum_r <= 2'd1;
                end else begin
                  if (wr) begin
                    res_r[0] <= '{kind: KIND_WRITE, entry_out: 5'(v),
                                  device_out: tdev_r[v], default: '0};
                    mblk_r[0] <= tblk_r[v];
                    dirty_r[v] <= 1'b0;
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                      if (LW'(i) < dlen_r && dord_r[i] == v) begin
                        for (int j = i; j < NUM_ENTRIES - 1; j++)
                          dord_r[j] <= dord_r[j+1];
                      end
                    end
                    dlen_r <= dlen_r - 1'b1;
                  end
                  r1 = ack(5'(v), 1'b0, ST_OK, 1'b0);
                  if (req_r.opcode == OP_READ) begin
                    r1.kind = KIND_READ;
                    r1.device_out = req_r.device;
                  end
                  res_r[wr] <= r1;
                  mblk_r[wr] <= req_r.block;
                  rnum_r <= wr ? 2'd2 : 2'd1;
                  fill_r[v] <= (req_r.opcode == OP_READ);
                  cnt_r[v]  <= COUNT_BITS'(1);
                  tdev_r[v] <= req_r.device;
                  tblk_r[v] <= req_r.block;
                  use_r[v]  <= 1'b1;
                end
              end
            end
            OP_RELEASE: begin
              rnum_r <= 2'd1;
              if (!ent_ok || cnt_r[ee] == '0) begin
                res_r[0] <= ack(req_r.entry, 1'b0, ST_UNUSED, 1'b0);
              end else begin
                cnt_r[ee] <= cnt_r[ee] - 1'b1;
                if (cnt_r[ee] == COUNT_BITS'(1)) begin
                  if (rlen_r < LW'(NUM_ENTRIES)) begin
                    rel_r[0] <= ee;
                    for (int j = 1; j < NUM_ENTRIES; j++) rel_r[j] <= rel_r[j-1];
                    rlen_r <= rlen_r + 1'b1;
                  end
                  res_r[0] <= ack(req_r.entry, 1'b0, ST_OK, 1'b1);
                end else begin
                  res_r[0] <= ack(req_r.entry, 1'b0, ST_OK, 1'b0);
                end
              end
            end
            OP_WB, OP_SETD: begin : wbsd
              logic nd, chg;
              rnum_r <= 2'd1;
              nd  = (req_r.opcode == OP_SETD) ? req_r.dirty_flag : 1'b0;
              chg = ent_ok && (dirty_r[ee] != nd);
              if (req_r.opcode == OP_WB && ent_ok && dirty_r[ee]) begin
                res_r[0] <= '{kind: KIND_WRITE, entry_out: req_r.entry,
                              device_out: tdev_r[ee], last: 1'b1, default: '0};
                mblk_r[0] <= tblk_r[ee];
                fill_r[ee] <= 1'b1;
              end else begin
                res_r[0] <= ack(req_r.entry, 1'b0, ST_OK, 1'b0);
              end
              if (chg) begin
                dirty_r[ee] <= nd;
                if (nd) begin
                  if (dlen_r < LW'(NUM_ENTRIES)) begin
                    dord_r[0] <= ee;
                    for (int j = 1; j < NUM_ENTRIES; j++) dord_r[j] <= dord_r[j-1];
                    dlen_r <= dlen_r + 1'b1;
                  end
                end else begin
                  for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (LW'(i) < dlen_r && dord_r[i] == ee) begin
                      for (int j = i; j < NUM_ENTRIES - 1; j++)
                        dord_r[j] <= dord_r[j+1];
                    end
                  end
                  dlen_r <= dlen_r - 1'b1;
                end
              end
            end
            OP_SYNC: begin
              res_r[0] <= ack(5'd0, 1'b0, ST_OK, 1'b0);
              rnum_r <= (dlen_r == '0) ? 2'd1 : 2'd0;
            end
            default: begin
              res_r[0] <= ack(5'd0, 1'b0, ST_OK, 1'b0);
              rnum_r <= 2'd1;
            end
          endcase
        end
        S_SYNC: begin
          if (out_free) begin
            // pop newest dirty entry straight to the output
            obuf_r <= '{kind: KIND_WRITE, entry_out: 5'(de), device_out: tdev_r[de],
                        sector: 35'(64'(tblk_r[de]) * 64'(spb)),
                        last: (dlen_r == LW'(1)) || (nsync_r == LW'(NUM_ENTRIES - 1)),
                        default: '0};
            ovld_r <= 1'b1;
            nsync_r <= nsync_r + 1'b1;
            dirty_r[de] <= 1'b0;
            fill_r[de]  <= 1'b1;
            for (int j = 0; j < NUM_ENTRIES - 1; j++) dord_r[j] <= dord_r[j+1];
            dlen_r <= dlen_r - 1'b1;
          end
        end
        S_MUL: begin
          if (res_r[ridx_r].kind != KIND_ACK)
            res_r[ridx_r].sector <= 35'(64'(mblk_r[ridx_r]) * 64'(spb));
        end
        S_EMIT: begin
          if (out_free) begin
            obuf_r <= res_r[ridx_r];
            ovld_r <= 1'b1;
            ridx_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_EXEC;
      S_EXEC: state_nxt = (req_r.opcode == OP_SYNC && dlen_r != '0) ? S_SYNC : S_MUL;
      S_SYNC: begin
        if (out_free && ((dlen_r == LW'(1)) || (nsync_r == LW'(NUM_ENTRIES - 1))))
          state_nxt = S_IDLE;
      end
      S_MUL:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          if (!ridx_r && rnum_r == 2'd2) state_nxt = S_MUL;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: design/block_buffer_cache_manager.sv
// Block buffer cache manager.
// Requests enter on in_valid/in_stall (payload in_data), results leave on
// out_valid/out_stall (payload out_data). A request is taken when valid is
// high and stall is low on a rising edge of clk.
// cfg_valid/cfg_ready write sectors_per_block (reset value 2); cfg_ready is
// low while a request waits in the queue or runs in the engine.
// The front accepts requests into a two-entry queue; the back engine runs
// one request at a time (pop, search, execute, multiply, emit) and pops no
// new one until its last result is in the output register. A dirty-victim
// miss runs multiply and emit again for its extra result; sync writes one
// dirty entry per cycle while the output register is free, after pop,
// search, execute. The tag compare and, but for sync, the sector multiply
// have steps of their own. The last result of each request carries last = 1.
// rst_n is synchronous and active low: all entries become unused, both
// orders empty, and the queue and output register empty.
// When out_stall is high the result register holds; the queue keeps
// taking requests until full, then in_stall rises.
module block_buffer_cache_manager (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bbcm_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bbcm_pkg::out_res_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import bbcm_pkg::*;

  logic [3:0] spb_r;
  logic       q_full, q_empty, q_pop, busy;
  in_req_t    q_data;

  assign in_stall  = q_full;
  assign cfg_ready = !busy && q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) spb_r <= 4'd2;
    else if (cfg_valid && cfg_ready) spb_r <= cfg_data;
  end

  bbcm_queue u_q (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_valid && !q_full), .wr_data(in_data), .full(q_full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  bbcm_engine u_eng (
    .clk(clk), .rst_n(rst_n), .spb(spb_r),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );
endmodule

// File: design/bbcm_checker.sv
module bbcm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bbcm_pkg::out_res_t out_data
);
  import bbcm_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("request dropped while stalled");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind != 2'd3)
    else $error("bad kind");

  a_write_notlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_ACK |-> out_data.status == ST_OK && !out_data.hit)
    else $error("disk request with status");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ACK |-> out_data.sector == '0 && out_data.last)
    else $error("ack fields wrong");
endmodule

bind block_buffer_cache_manager bbcm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: test/block_buffer_cache_manager_tb.sv
`timescale 1ns / 100ps

module block_buffer_cache_manager_tb;
  import bbcm_pkg::*;

  class cache_scoreboard;
    logic [3:0] spb;
    logic [7:0] tdev [NUM_ENTRIES];
    logic [31:0] tblk [NUM_ENTRIES];
    bit in_use [NUM_ENTRIES];
    int unsigned refs [NUM_ENTRIES];
    bit filled [NUM_ENTRIES];
    bit dirty [NUM_ENTRIES];
    int unsigned handed;
    int lru_q[$];
    int dirty_q[$];
    out_res_t pending[$];
    int errors;
    int checked;
    int syncs;
    int hits;

    function new();
      spb = 4'd2;
      handed = 0;
      errors = 0;
      checked = 0;
      syncs = 0;
      hits = 0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        in_use[i] = 0;
        refs[i] = 0;
        filled[i] = 0;
        dirty[i] = 0;
        tdev[i] = '0;
        tblk[i] = '0;
      end
    endfunction

    function void drop_from(ref int q[$], input int e);
      for (int i = 0; i < q.size(); i++) begin
        if (q[i] == e) begin
          q.delete(i);
          return;
        end
      end
    endfunction

    function void mark_dirty(int e, bit d);
      if (dirty[e] == d) return;
      dirty[e] = d;
      if (d) dirty_q.push_front(e);
      else drop_from(dirty_q, e);
    endfunction

    function void add(logic [1:0] kind, int e, logic [7:0] dev, logic [34:0] sec,
                      bit hit, logic [1:0] st, bit wake, bit last);
      out_res_t r;
      r.kind = kind;
      r.entry_out = e[4:0];
      r.device_out = dev;
      r.sector = sec;
      r.hit = hit;
      r.status = st;
      r.wake_waiter = wake;
      r.last = last;
      pending.push_back(r);
    endfunction

    function logic [34:0] sector_of(logic [31:0] b);
      logic [35:0] p;
      p = b * spb;
      return p[34:0];
    endfunction

    function void flush_entry(int e, bit last);
      add(KIND_WRITE, e, tdev[e], sector_of(tblk[e]), 0, ST_OK, 0, last);
      mark_dirty(e, 0);
      filled[e] = 1;
    endfunction

    function void lookup(logic [7:0] dev, logic [31:0] blk, bit rd);
      int e;
      e = -1;
      for (int i = 0; i < handed; i++)
        if (in_use[i] && tdev[i] == dev && tblk[i] == blk) begin
          e = i;
          break;
        end
      if (e >= 0) begin
        hits++;
        if (!filled[e] || refs[e] >= COUNT_MAX) begin
          add(KIND_ACK, e, 0, 0, 1, ST_BUSY, 0, 1);
          return;
        end
        refs[e]++;
        if (refs[e] == 1) drop_from(lru_q, e);
        add(KIND_ACK, e, 0, 0, 1, ST_OK, 0, 1);
        return;
      end
      if (handed < NUM_ENTRIES) begin
        e = handed;
        handed++;
        dirty[e] = 0;
      end else if (lru_q.size() > 0) begin
        e = lru_q.pop_back();
        if (dirty[e]) flush_entry(e, 0);
      end else begin
        add(KIND_ACK, 0, 0, 0, 0, ST_NOFREE, 0, 1);
        return;
      end
      filled[e] = 0;
      refs[e] = 1;
      tdev[e] = dev;
      tblk[e] = blk;
      in_use[e] = 1;
      if (rd) begin
        add(KIND_READ, e, dev, sector_of(blk), 0, ST_OK, 0, 1);
        filled[e] = 1;
      end else begin
        add(KIND_ACK, e, 0, 0, 0, ST_OK, 0, 1);
      end
    endfunction

    function void note_request(in_req_t r);
      int e;
      bit ok;
      int n;
      e = r.entry;
      ok = e < handed;
      case (r.opcode)
        OP_GET: lookup(r.device, r.block, 0);
        OP_READ: lookup(r.device, r.block, 1);
        OP_RELEASE: begin
          if (!ok || refs[e] == 0) add(KIND_ACK, e, 0, 0, 0, ST_UNUSED, 0, 1);
          else begin
            refs[e]--;
            if (refs[e] == 0) begin
              if (lru_q.size() < NUM_ENTRIES) lru_q.push_front(e);
              add(KIND_ACK, e, 0, 0, 0, ST_OK, 1, 1);
            end else add(KIND_ACK, e, 0, 0, 0, ST_OK, 0, 1);
          end
        end
        OP_WB: begin
          if (ok && dirty[e]) flush_entry(e, 1);
          else add(KIND_ACK, e, 0, 0, 0, ST_OK, 0, 1);
        end
        OP_SETD: begin
          if (ok) mark_dirty(e, r.dirty_flag);
          add(KIND_ACK, e, 0, 0, 0, ST_OK, 0, 1);
        end
        OP_SYNC: begin
          syncs++;
          n = 0;
          while (dirty_q.size() > 0 && n < 32) begin
            n++;
            flush_entry(dirty_q[0], dirty_q.size() == 1 || n == 32);
          end
          if (n == 0) add(KIND_ACK, 0, 0, 0, 0, ST_OK, 0, 1);
        end
        default: add(KIND_ACK, 0, 0, 0, 0, ST_OK, 0, 1);
      endcase
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_req_t in_data;
  logic out_valid;
  logic out_stall;
  out_res_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_data;

  cache_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int idle_cycles;
  int requests_sent;
  bit timed_out;
  logic [7:0] recent_dev [8];
  logic [31:0] recent_blk [8];

  block_buffer_cache_manager u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("block_buffer_cache_manager regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_spb(logic [3:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.spb = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_req_t make_req(logic [2:0] op, logic [7:0] dev, logic [31:0] blk,
                                       logic [4:0] e, bit d);
    in_req_t r;
    r.opcode = op;
    r.device = dev;
    r.block = blk;
    r.entry = e;
    r.dirty_flag = d;
    return r;
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    int pick;
    int k;
    r = in_req_t'($bits(in_req_t)'({$urandom, $urandom}));
    pick = $urandom_range(99);
    k = $urandom_range(7);
    if (pick < 50) begin
      r.opcode = $urandom_range(1) ? OP_READ : OP_GET;
      if ($urandom_range(1)) begin
        r.device = recent_dev[k];
        r.block = recent_blk[k];
      end else begin
        recent_dev[k] = r.device;
        recent_blk[k] = r.block;
      end
    end else if (pick < 75) r.opcode = OP_RELEASE;
    else if (pick < 85) r.opcode = OP_SETD;
    else if (pick < 92) r.opcode = OP_WB;
    else if (pick < 97) r.opcode = OP_SYNC;
    else r.opcode = 3'($urandom_range(7));
    return r;
  endfunction

  task automatic random_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (n) send_request(random_req());
    stop_sending();
  endtask

  initial begin
    sb = new();
    timed_out = 0;
    idle_cycles = 0;
    requests_sent = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 4'd0;
    for (int i = 0; i < 8; i++) begin
      recent_dev[i] = 8'($urandom);
      recent_blk[i] = $urandom;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_WB, 8'h00, 32'h0, 5'd31, 0));
    send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'd31, 1));
    send_request(make_req(OP_SYNC, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_GET, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_GET, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_READ, 8'hff, 32'hffff_ffff, 5'd0, 0));
    send_request(make_req(OP_READ, 8'hff, 32'hffff_ffff, 5'd0, 0));
    send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'd1, 1));
    send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'd0, 1));
    send_request(make_req(OP_WB, 8'h00, 32'h0, 5'd1, 0));
    send_request(make_req(OP_WB, 8'h00, 32'h0, 5'd1, 0));
    send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'd1, 1));
    send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_SYNC, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd1, 0));
    send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd1, 0));
    send_request(make_req(3'd6, 8'h00, 32'h0, 5'd0, 0));
    send_request(make_req(3'd7, 8'h00, 32'h0, 5'd0, 0));
    stop_sending();

    write_spb(4'd8);
    for (int i = 0; i < 34; i++)
      send_request(make_req(i % 2 ? OP_READ : OP_GET, 8'(i), 32'hf000_0000 + i, 5'd0, 0));
    for (int i = 0; i < 32; i++)
      send_request(make_req(OP_SETD, 8'h00, 32'h0, 5'(i), 1));
    send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd5, 0));
    send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'd5, 0));
    send_request(make_req(OP_GET, 8'h77, 32'h1234, 5'd0, 0));
    send_request(make_req(OP_SYNC, 8'h00, 32'h0, 5'd0, 0));
    for (int i = 0; i < 32; i++)
      send_request(make_req(OP_RELEASE, 8'h00, 32'h0, 5'(i), 0));
    stop_sending();

    write_spb(4'd1);
    random_phase(40, 0, 0);
    write_spb(4'd0);
    random_phase(30, 51, 0);
    write_spb(4'd15);
    random_phase(30, 0, 51);
    write_spb(4'd3);
    random_phase(30, 15, 15);

    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      random_phase(30, 0, 0);
    join
    wait_drained();
    random_phase(20, 0, 0);

    wait_drained();
    repeat (100) @(negedge clk);
    $display("covered %0d requests, %0d results checked, %0d hits, %0d syncs",
             requests_sent, sb.checked, sb.hits, sb.syncs);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("block_buffer_cache_manager regression: pass");
    else
      $display("block_buffer_cache_manager regression: fail");
    $finish;
  end
endmodule
